### hdl/gvdmf_pkg.sv
// ---------------------------------------------------------------------------
// gvdmf_pkg
// shared constants and types of the grid vertex-disjoint max-flow block
// ---------------------------------------------------------------------------
package gvdmf_pkg;

  localparam int MAX_ROWS  = 16;
  localparam int MAX_COLS  = 16;
  localparam int CELL_CAP  = MAX_ROWS * MAX_COLS;
  localparam int CELL_W    = (CELL_CAP > 1) ? $clog2(CELL_CAP) : 1;
  localparam int NODE_CAP  = 2 * CELL_CAP;
  localparam int NODE_W    = CELL_W + 1;
  localparam int Q_CNT_W   = NODE_W + 1;
  localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
  localparam int COL_CNT_W = $clog2(MAX_COLS + 1);

  localparam int CFG_W     = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_W     = 5;
  localparam int TDATA_W   = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;
  localparam logic [CFG_W-1:0]     CFG_RESET     = 5'd16;

  localparam logic [1:0] DIR_UP    = 2'd0;
  localparam logic [1:0] DIR_DOWN  = 2'd1;
  localparam logic [1:0] DIR_LEFT  = 2'd2;
  localparam logic [1:0] DIR_RIGHT = 2'd3;

  typedef logic [CELL_W-1:0]    cell_t;
  typedef logic [ROW_W-1:0]     row_t;
  typedef logic [COL_W-1:0]     col_t;
  typedef logic [ROW_CNT_W-1:0] row_cnt_t;
  typedef logic [COL_CNT_W-1:0] col_cnt_t;

  // one cell request from the front to the solver
  typedef struct packed {
    logic  cell_open;
    logic  last_cell;
    cell_t load_index;
  } cmd_t;

endpackage

### hdl/gvdmf_front.sv
// ---------------------------------------------------------------------------
// gvdmf_front
// accepts cells, numbers them in load order and marks the grid end
// ---------------------------------------------------------------------------
module gvdmf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            cell_open,
  input  logic            last_cell,
  output logic            push,
  input  logic            push_ready,
  output gvdmf_pkg::cmd_t push_cmd
);
  import gvdmf_pkg::*;

  cell_t load_index;

  assign in_ready = push_ready;
  assign push     = in_valid && push_ready;

  always_comb begin
    push_cmd.cell_open  = cell_open;
    push_cmd.last_cell  = last_cell;
    push_cmd.load_index = load_index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
    end else if (push) begin
      // the grid end, or the last position of the store, restarts loading at the first position
      if (last_cell || load_index == cell_t'(CELL_CAP - 1)) begin
        load_index <= '0;
      end else begin
        load_index <= load_index + cell_t'(1);
      end
    end
  end

endmodule

### hdl/gvdmf_cmd_fifo.sv
// ---------------------------------------------------------------------------
// gvdmf_cmd_fifo
// two-entry request queue between the front and the solver
// ---------------------------------------------------------------------------
module gvdmf_cmd_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            push_ready,
  input  gvdmf_pkg::cmd_t push_cmd,
  output logic            pop_valid,
  input  logic            pop,
  output gvdmf_pkg::cmd_t pop_cmd
);
  import gvdmf_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign push_ready = fill != 2'd2;
  assign pop_valid  = fill != 2'd0;
  assign pop_cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && push_ready) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push && push_ready) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push && push_ready, pop && pop_valid})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hdl/gvdmf_solver.sv
// ---------------------------------------------------------------------------
// gvdmf_solver
// stores the grid and runs breadth-first augmenting searches over it
// ---------------------------------------------------------------------------
module gvdmf_solver (
  input  logic                          clk,
  input  logic                          rst,
  input  gvdmf_pkg::row_cnt_t           rows,
  input  gvdmf_pkg::col_cnt_t           cols,
  input  logic                          cmd_valid,
  output logic                          cmd_pop,
  input  gvdmf_pkg::cmd_t               cmd,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic [gvdmf_pkg::OUT_W-1:0]   res_count
);
  import gvdmf_pkg::*;

  typedef struct packed {
    row_t r;
    col_t c;
    logic side;   // 0 in node, 1 out node
  } node_t;

  typedef struct packed {
    logic  seen;
    logic  from_src;
    node_t node;
  } par_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CLR_FLOW, S_CLR_PAR, S_SRC, S_POP, S_NODE, S_CAND_RD, S_CAND_EV,
    S_CAND_CHK, S_AUG_SINK, S_AUG_PAR, S_AUG_WR, S_NEXT, S_DONE
  } state_t;

  localparam logic [2:0] K_LAST = 3'd4;

  function automatic cell_t cell_of(row_t r, col_t c, col_cnt_t ncols);
    return cell_t'(r) * cell_t'(ncols) + cell_t'(c);
  endfunction

  function automatic logic [NODE_W-1:0] addr_of(node_t n, col_cnt_t ncols);
    return {cell_of(n.r, n.c, ncols), n.side};
  endfunction

  // direction of the step from a to its neighbor b
  function automatic logic [1:0] dir_of(node_t a, node_t b);
    logic [1:0] d;
    if ({1'b0, b.r} + 1'b1 == {1'b0, a.r}) begin
      d = DIR_UP;
    end else if ({1'b0, a.r} + 1'b1 == {1'b0, b.r}) begin
      d = DIR_DOWN;
    end else if ({1'b0, b.c} + 1'b1 == {1'b0, a.c}) begin
      d = DIR_LEFT;
    end else begin
      d = DIR_RIGHT;
    end
    return d;
  endfunction

  // storage
  logic  open_mem [CELL_CAP];
  logic [4:0] flow_mem [CELL_CAP];   // [4] split, [3:0] move per direction
  par_t  par_mem [NODE_CAP];
  node_t q_mem [NODE_CAP];

  logic       open_rd;
  logic [4:0] flow_rd;
  par_t       par_rd;
  node_t      q_rd;

  state_t               state;
  logic [NODE_W-1:0]    cnt;
  col_t                 cc;
  logic [Q_CNT_W-1:0]   head;
  logic [Q_CNT_W-1:0]   tail;
  node_t                u_reg;
  node_t                v_reg;
  node_t                sink_par;
  logic [2:0]           k;
  col_cnt_t             flow_total;
  logic [MAX_COLS-1:0]  top_flow;
  logic [MAX_COLS-1:0]  bottom_flow;
  cell_t                aug_addr;
  logic                 aug_split;
  logic                 aug_val;
  logic [1:0]           aug_d;

  // candidate decode
  logic [1:0] cand_d;
  logic       cand_ok;
  logic       cand_cond;
  node_t      cand_v;
  row_t       y_r;
  col_t       y_c;
  cell_t      x_u;
  cell_t      x_y;
  cell_t      cand_addr;

  // augment decode
  node_t      par_node;
  logic       par_same;
  cell_t      x_p;
  cell_t      x_v;
  logic [4:0] flow_mod;

  // memory port controls
  logic               open_we;
  logic               flow_we;
  cell_t              flow_waddr;
  logic [4:0]         flow_wdata;
  cell_t              flow_raddr;
  logic               par_we;
  logic [NODE_W-1:0]  par_waddr;
  par_t               par_wdata;
  logic [NODE_W-1:0]  par_raddr;
  logic               q_we;
  node_t              q_wdata;

  assign cand_d = 2'(k - 3'd1);
  assign x_u    = cell_of(u_reg.r, u_reg.c, cols);
  assign x_y    = cell_of(y_r, y_c, cols);

  always_comb begin
    y_r     = u_reg.r;
    y_c     = u_reg.c;
    cand_ok = 1'b1;
    if (k != 3'd0) begin
      unique case (cand_d)
        DIR_UP: begin
          cand_ok = u_reg.r != '0;
          y_r     = u_reg.r - row_t'(1);
        end
        DIR_DOWN: begin
          cand_ok = row_cnt_t'(u_reg.r) + row_cnt_t'(1) < rows;
          y_r     = u_reg.r + row_t'(1);
        end
        DIR_LEFT: begin
          cand_ok = u_reg.c != '0;
          y_c     = u_reg.c - col_t'(1);
        end
        DIR_RIGHT: begin
          cand_ok = col_cnt_t'(u_reg.c) + col_cnt_t'(1) < cols;
          y_c     = u_reg.c + col_t'(1);
        end
        default: cand_ok = 1'b0;
      endcase
    end
    cand_v.r    = y_r;
    cand_v.c    = y_c;
    cand_v.side = ~u_reg.side;
    // out nodes test their own move bits, in nodes those of the neighbor
    cand_addr = (k == 3'd0 || u_reg.side) ? x_u : x_y;
  end

  always_comb begin
    if (k == 3'd0) begin
      cand_cond = u_reg.side ? flow_rd[4] : (open_rd && !flow_rd[4]);
    end else begin
      cand_cond = u_reg.side ? !flow_rd[cand_d] : flow_rd[cand_d ^ 2'd1];
    end
  end

  assign par_node = par_rd.node;
  assign par_same = par_node.r == v_reg.r && par_node.c == v_reg.c;
  assign x_p      = cell_of(par_node.r, par_node.c, cols);
  assign x_v      = cell_of(v_reg.r, v_reg.c, cols);

  always_comb begin
    flow_mod = flow_rd;
    if (aug_split) begin
      flow_mod[4] = aug_val;
    end else begin
      flow_mod[aug_d] = aug_val;
    end
  end

  always_comb begin
    cmd_pop    = 1'b0;
    open_we    = 1'b0;
    flow_we    = 1'b0;
    flow_waddr = aug_addr;
    flow_wdata = flow_mod;
    flow_raddr = cand_addr;
    par_we     = 1'b0;
    par_waddr  = addr_of(v_reg, cols);
    par_wdata  = '0;
    par_raddr  = addr_of(v_reg, cols);
    q_we       = 1'b0;
    q_wdata    = v_reg;
    unique case (state)
      S_IDLE: begin
        cmd_pop = cmd_valid;
        open_we = cmd_valid;
      end
      S_CLR_FLOW: begin
        flow_we    = 1'b1;
        flow_waddr = cnt[CELL_W-1:0];
        flow_wdata = '0;
      end
      S_CLR_PAR: begin
        par_we    = 1'b1;
        par_waddr = cnt;
      end
      S_SRC: begin
        par_we             = !top_flow[cc];
        par_waddr          = {cell_t'(cc), 1'b0};
        par_wdata.seen     = 1'b1;
        par_wdata.from_src = 1'b1;
        q_we               = !top_flow[cc];
        q_wdata.r          = '0;
        q_wdata.c          = cc;
        q_wdata.side       = 1'b0;
      end
      S_CAND_CHK: begin
        par_we         = !par_rd.seen;
        par_wdata.seen = 1'b1;
        par_wdata.node = u_reg;
        q_we           = !par_rd.seen;
      end
      S_AUG_SINK: begin
        par_raddr = addr_of(sink_par, cols);
      end
      S_AUG_PAR: begin
        flow_raddr = (par_node.side && !par_same) ? x_p : x_v;
      end
      S_AUG_WR: begin
        flow_we   = 1'b1;
        par_raddr = addr_of(u_reg, cols);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (open_we) begin
      open_mem[cmd.load_index] <= cmd.cell_open;
    end
    open_rd <= open_mem[flow_raddr];
  end

  always_ff @(posedge clk) begin
    if (flow_we) begin
      flow_mem[flow_waddr] <= flow_wdata;
    end
    flow_rd <= flow_mem[flow_raddr];
  end

  always_ff @(posedge clk) begin
    if (par_we) begin
      par_mem[par_waddr] <= par_wdata;
    end
    par_rd <= par_mem[par_raddr];
  end

  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[tail[NODE_W-1:0]] <= q_wdata;
    end
    q_rd <= q_mem[head[NODE_W-1:0]];
  end

  // payload of the walk
  always_ff @(posedge clk) begin
    unique case (state)
      S_NODE: begin
        u_reg    <= q_rd;
        sink_par <= q_rd;
      end
      S_CAND_RD: v_reg <= cand_v;
      S_AUG_SINK: v_reg <= sink_par;
      S_AUG_PAR: begin
        u_reg     <= par_node;
        aug_addr  <= (par_node.side && !par_same) ? x_p : x_v;
        aug_split <= par_same;
        aug_val   <= par_same ? ~par_node.side : par_node.side;
        aug_d     <= par_node.side ? dir_of(par_node, v_reg) : dir_of(v_reg, par_node);
      end
      S_AUG_WR: v_reg <= u_reg;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      cc          <= '0;
      head        <= '0;
      tail        <= '0;
      k           <= '0;
      flow_total  <= '0;
      top_flow    <= '0;
      bottom_flow <= '0;
      res_valid   <= 1'b0;
      res_count   <= '0;
    end else begin
      // the finish step sets the flag itself
      if (res_valid && res_ready && state != S_DONE) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid && cmd.last_cell) begin
            cnt         <= '0;
            flow_total  <= '0;
            top_flow    <= '0;
            bottom_flow <= '0;
            state       <= S_CLR_FLOW;
          end
        end
        S_CLR_FLOW: begin
          cnt <= cnt + 1'b1;
          if (cnt[CELL_W-1:0] == cell_t'(CELL_CAP - 1)) begin
            cnt   <= '0;
            state <= S_CLR_PAR;
          end
        end
        S_CLR_PAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == NODE_W'(NODE_CAP - 1)) begin
            cc    <= '0;
            head  <= '0;
            tail  <= '0;
            state <= S_SRC;
          end
        end
        S_SRC: begin
          if (!top_flow[cc]) begin
            tail <= tail + 1'b1;
          end
          cc <= cc + col_t'(1);
          if (col_cnt_t'(cc) + col_cnt_t'(1) == cols) begin
            state <= S_POP;
          end
        end
        S_POP: begin
          if (head == tail) begin
            state <= S_DONE;
          end else begin
            head  <= head + 1'b1;
            state <= S_NODE;
          end
        end
        S_NODE: begin
          k <= '0;
          if (q_rd.side && row_cnt_t'(q_rd.r) + row_cnt_t'(1) == rows &&
              !bottom_flow[q_rd.c]) begin
            state <= S_AUG_SINK;
          end else begin
            state <= S_CAND_RD;
          end
        end
        S_CAND_RD: begin
          if (cand_ok) begin
            state <= S_CAND_EV;
          end else if (k == K_LAST) begin
            state <= S_POP;
          end else begin
            k <= k + 3'd1;
          end
        end
        S_CAND_EV: begin
          if (cand_cond) begin
            state <= S_CAND_CHK;
          end else if (k == K_LAST) begin
            state <= S_POP;
          end else begin
            k     <= k + 3'd1;
            state <= S_CAND_RD;
          end
        end
        S_CAND_CHK: begin
          if (!par_rd.seen) begin
            tail <= tail + 1'b1;
          end
          if (k == K_LAST) begin
            state <= S_POP;
          end else begin
            k     <= k + 3'd1;
            state <= S_CAND_RD;
          end
        end
        S_AUG_SINK: begin
          bottom_flow[sink_par.c] <= 1'b1;
          state                   <= S_AUG_PAR;
        end
        S_AUG_PAR: begin
          if (par_rd.from_src) begin
            top_flow[v_reg.c] <= 1'b1;
            flow_total        <= flow_total + col_cnt_t'(1);
            state             <= S_NEXT;
          end else begin
            state <= S_AUG_WR;
          end
        end
        S_AUG_WR: state <= S_AUG_PAR;
        S_NEXT: begin
          if (flow_total < cols) begin
            cnt   <= '0;
            state <= S_CLR_PAR;
          end else begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!res_valid || res_ready) begin
            res_valid <= 1'b1;
            res_count <= OUT_W'(flow_total);
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_queue_order: assert property (@(posedge clk) disable iff (rst) head <= tail)
    else $error("search queue head passed its tail");

  // the count of the previous grid may exceed a later, narrower shape
  a_flow_bound: assert property (@(posedge clk) disable iff (rst)
    state != S_IDLE |-> flow_total <= cols)
    else $error("path count exceeds the number of columns");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_DONE)
    else $error("result raised outside the finish step");

endmodule

### hdl/grid_vertex_disjoint_max_flow.sv
// ---------------------------------------------------------------------------
// grid_vertex_disjoint_max_flow
// counts vertex-disjoint top-to-bottom paths through an open/blocked grid
// ---------------------------------------------------------------------------
// channel   direction  content
// s_axis    in         one cell: tdata[0] cell_open, tlast last_cell
// m_axis    out        one result per grid: tdata[4:0] path_count
// cfg       in         register write: index 0 row_count, 1 col_count
//
// a cell without tlast is stored when the idle solver takes it; cells queue
// two deep ahead of the solver. a cell with tlast starts the solve: a flow
// clear of MAX_ROWS*MAX_COLS entries, then per augmenting search a parent
// clear of 2*MAX_ROWS*MAX_COLS entries, a source step per column, candidate
// checks for every visited node and a walk back along each found path.
// input stalls when the queue is full; rst is synchronous, registers go to 16.
// ---------------------------------------------------------------------------
module grid_vertex_disjoint_max_flow (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [gvdmf_pkg::TDATA_W-1:0]     s_axis_tdata,   // [0] cell_open
  input  logic                              s_axis_tlast,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [gvdmf_pkg::TDATA_W-1:0]     m_axis_tdata,   // [4:0] path_count
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gvdmf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gvdmf_pkg::CFG_W-1:0]       cfg_data
);
  import gvdmf_pkg::*;

  logic [CFG_W-1:0] row_count;
  logic [CFG_W-1:0] col_count;
  row_cnt_t         rows;
  col_cnt_t         cols;
  logic             push;
  logic             push_ready;
  cmd_t             push_cmd;
  logic             pop_valid;
  logic             pop;
  cmd_t             pop_cmd;
  logic [OUT_W-1:0] res_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= CFG_RESET;
      col_count <= CFG_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_ROW_COUNT) begin
        row_count <= cfg_data;
      end else if (cfg_index == CFG_COL_COUNT) begin
        col_count <= cfg_data;
      end
    end
  end

  // clamp the grid size into the supported range
  always_comb begin
    priority if (row_count == '0) begin
      rows = row_cnt_t'(1);
    end else if (int'(row_count) > MAX_ROWS) begin
      rows = row_cnt_t'(MAX_ROWS);
    end else begin
      rows = row_cnt_t'(row_count);
    end
    priority if (col_count == '0) begin
      cols = col_cnt_t'(1);
    end else if (int'(col_count) > MAX_COLS) begin
      cols = col_cnt_t'(MAX_COLS);
    end else begin
      cols = col_cnt_t'(col_count);
    end
  end

  gvdmf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .cell_open  (s_axis_tdata[0]),
    .last_cell  (s_axis_tlast),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  gvdmf_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_cmd    (pop_cmd)
  );

  gvdmf_solver u_solver (
    .clk       (clk),
    .rst       (rst),
    .rows      (rows),
    .cols      (cols),
    .cmd_valid (pop_valid),
    .cmd_pop   (pop),
    .cmd       (pop_cmd),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res_count (res_count)
  );

  assign m_axis_tdata = {{(TDATA_W - OUT_W){1'b0}}, res_count};

endmodule

### test/grid_vertex_disjoint_max_flow_tb.sv
// ---------------------------------------------------------------------------
// grid_vertex_disjoint_max_flow_tb
// Drives percolation grids cell by cell into the block and checks each path
// count against a breadth-first max-flow solver kept in a scoreboard class.
// Runs directed small grids, then random grids over several grid shapes
// and with different patterns of sender idling and receiver stalling.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module grid_vertex_disjoint_max_flow_tb;
  import gvdmf_pkg::*;

  localparam int NODE_N = 2 * CELL_CAP + 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd2;
  localparam int CYCLE_LIMIT = 6000000;

  class flow_book;
    bit             open_map[CELL_CAP];
    bit             split_flow[CELL_CAP];
    bit [3:0]       move_flow[CELL_CAP];
    bit             top_flow[MAX_COLS];
    bit             bottom_flow[MAX_COLS];
    int unsigned    parent[NODE_N];
    bit             seen[NODE_N];
    int unsigned    bfs_queue[NODE_N];
    int unsigned    q_tail;
    int unsigned    load_idx;
    logic [4:0]     row_reg;
    logic [4:0]     col_reg;
    int unsigned    g_rows;
    int unsigned    g_cols;
    logic [4:0]     pending_counts[$];
    int             errors;

    function new();
      foreach (open_map[i]) open_map[i] = 0;
      load_idx = 0;
      row_reg  = CFG_RESET;
      col_reg  = CFG_RESET;
      errors   = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == CFG_ROW_COUNT) row_reg = val;
      else if (idx == CFG_COL_COUNT) col_reg = val;
    endfunction

    function bit step_to(int unsigned x, logic [1:0] d, output int unsigned y);
      int unsigned r, c;
      r = x / g_cols;
      c = x % g_cols;
      y = 0;
      case (d)
        DIR_UP: begin
          if (r == 0) return 0;
          y = x - g_cols;
        end
        DIR_DOWN: begin
          if (r + 1 >= g_rows) return 0;
          y = x + g_cols;
        end
        DIR_LEFT: begin
          if (c == 0) return 0;
          y = x - 1;
        end
        default: begin
          if (c + 1 >= g_cols) return 0;
          y = x + 1;
        end
      endcase
      return 1;
    endfunction

    function void visit(int unsigned u, int unsigned v);
      if (v < NODE_N && !seen[v] && q_tail < NODE_N) begin
        seen[v] = 1;
        parent[v] = u;
        bfs_queue[q_tail] = v;
        q_tail++;
      end
    endfunction

    function bit find_path(int unsigned src, int unsigned snk);
      int unsigned head, u, x, y;
      logic [1:0] d;
      head = 0;
      foreach (seen[i]) seen[i] = 0;
      q_tail = 0;
      visit(src, src);
      while (head < q_tail) begin
        u = bfs_queue[head];
        head++;
        if (u == snk) return 1;
        if (u == src) begin
          for (int c = 0; c < g_cols; c++)
            if (!top_flow[c]) visit(u, 2 * c);
        end else begin
          x = u / 2;
          if (u[0] == 0) begin
            if (open_map[x] && !split_flow[x]) visit(u, u + 1);
            for (int k = 0; k < 4; k++) begin
              d = k;
              // residual of a used move into this cell
              if (step_to(x, d, y) && move_flow[y][d ^ 2'd1]) visit(u, 2 * y + 1);
            end
          end else begin
            if (split_flow[x]) visit(u, u - 1);
            for (int k = 0; k < 4; k++) begin
              d = k;
              if (step_to(x, d, y) && !move_flow[x][d]) visit(u, 2 * y);
            end
            if (x / g_cols == g_rows - 1 && !bottom_flow[x % g_cols]) visit(u, snk);
          end
        end
      end
      return 0;
    endfunction

    function void push_unit(int unsigned u, int unsigned v, int unsigned src,
                            int unsigned snk);
      int unsigned y;
      logic [1:0] d;
      if (v == snk) bottom_flow[(u / 2) % g_cols] = 1;
      else if (u == src) top_flow[(v / 2) % g_cols] = 1;
      else if (u / 2 == v / 2) split_flow[u / 2] = u[0] ? 0 : 1;
      else if (u[0]) begin
        for (int k = 0; k < 4; k++) begin
          d = k;
          if (step_to(u / 2, d, y) && y == v / 2) move_flow[u / 2][d] = 1;
        end
      end else begin
        for (int k = 0; k < 4; k++) begin
          d = k;
          if (step_to(v / 2, d, y) && y == u / 2) move_flow[v / 2][d] = 0;
        end
      end
    endfunction

    function logic [4:0] count_paths();
      int unsigned src, snk, v, u, guard, total;
      g_rows = (row_reg < 1) ? 1 : ((row_reg > MAX_ROWS) ? MAX_ROWS : row_reg);
      g_cols = (col_reg < 1) ? 1 : ((col_reg > MAX_COLS) ? MAX_COLS : col_reg);
      src = 2 * g_rows * g_cols;
      snk = src + 1;
      foreach (split_flow[i]) split_flow[i] = 0;
      foreach (move_flow[i]) move_flow[i] = 0;
      foreach (top_flow[i]) top_flow[i] = 0;
      foreach (bottom_flow[i]) bottom_flow[i] = 0;
      total = 0;
      while (total < g_cols && find_path(src, snk)) begin
        v = snk;
        guard = 0;
        while (v != src && guard < NODE_N) begin
          u = parent[v];
          push_unit(u, v, src, snk);
          v = u;
          guard++;
        end
        total++;
      end
      return total[4:0];
    endfunction

    function void note_cell(bit cell_open, bit last_cell);
      open_map[load_idx] = cell_open;
      load_idx = (load_idx + 1) % CELL_CAP;
      if (last_cell) begin
        pending_counts.insert(pending_counts.size(), count_paths());
        load_idx = 0;
      end
    endfunction

    function void check_count(logic [4:0] actual);
      logic [4:0] want;
      if (pending_counts.size() == 0) begin
        $display("%0t: path count %0d with no request outstanding", $time, actual);
        errors++;
        return;
      end
      want = pending_counts.pop_front();
      if (actual !== want) begin
        $display("%0t: path_count mismatch, expected %0d actual %0d", $time, want, actual);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  flow_book book;
  int       send_idle_pct;
  int       recv_stall_pct;
  int       cycles;

  grid_vertex_disjoint_max_flow u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // result side: check on handshake, then pick next ready
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) book.check_count(m_axis_tdata[OUT_W-1:0]);
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_cell(bit cell_open, bit last_cell);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {{(TDATA_W-1){1'b0}}, cell_open};
    s_axis_tlast  <= last_cell;
    do @(posedge clk); while (!s_axis_tready);
    book.note_cell(cell_open, last_cell);
  endtask

  task automatic send_grid(int n, int density);
    for (int i = 0; i < n; i++) send_cell($urandom_range(99) < density, i == n - 1);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 0;
    s_axis_tlast  <= 0;
    do @(posedge clk); while (book.pending_counts.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    book.write_reg(idx, val);
  endtask

  task automatic set_shape(logic [CFG_W-1:0] r, logic [CFG_W-1:0] c);
    write_reg(CFG_ROW_COUNT, r);
    write_reg(CFG_COL_COUNT, c);
  endtask

  initial begin
    int sent, n, rr, cc;
    book = new();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst = 1;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tlast = 0;
    m_axis_tready = 0;
    cfg_valid = 0;
    cfg_index = CFG_ROW_COUNT;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // single cell, open then blocked
    set_shape(5'd1, 5'd1);
    send_cell(1, 1);
    send_cell(0, 1);
    wait_idle();
    // unused index is ignored, zero sizes saturate up to one
    write_reg(CFG_UNUSED, 5'd7);
    set_shape(5'd0, 5'd0);
    send_cell(1, 1);
    // overlong grid: extra cells land past the single cell in use
    send_cell(1, 0);
    send_cell(0, 0);
    send_cell(1, 1);
    wait_idle();
    // 2x2 checker, all open, then a short grid over earlier contents
    set_shape(5'd2, 5'd2);
    send_cell(1, 0); send_cell(0, 0); send_cell(0, 0); send_cell(1, 1);
    send_cell(1, 0); send_cell(1, 0); send_cell(1, 0); send_cell(1, 1);
    send_cell(0, 0); send_cell(1, 1);
    wait_idle();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      case (ph)
        0:  begin rr = 31; cc = 31; end
        1:  begin rr = 1;  cc = 16; end
        2:  begin rr = 16; cc = 1;  end
        5:  begin rr = 16; cc = 16; end
        default: begin rr = $urandom_range(1, 5); cc = $urandom_range(1, 5); end
      endcase
      set_shape(rr, cc);
      if (rr > MAX_ROWS) rr = MAX_ROWS;
      if (cc > MAX_COLS) cc = MAX_COLS;
      sent = 0;
      while (sent < 25) begin
        n = rr * cc;
        // the first large grid writes every position, after that lengths vary
        if (ph != 0 && $urandom_range(9) == 0) n = n + $urandom_range(2) - 1;
        if (n < 1) n = 1;
        send_grid(n, $urandom_range(40, 95));
        sent += n;
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (book.pending_counts.size() != 0) begin
      $display("%0t: %0d path counts never arrived", $time, book.pending_counts.size());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
